>>> design/hmc_pkg.sv
// Shared types, constants and the per-slot offset table for the hexahedral mesh
// connectivity generator.
// No dependencies; every other design file imports this package.
package hmc_pkg;

	localparam int MAX_CELLS_DEFAULT = 256;
	localparam int QUEUE_DEPTH       = 2;

	localparam int COORD_W    = 8;
	localparam int CFG_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CELL_IDX_W = 24;
	localparam int ID_W       = 26;
	localparam int SLOT_W     = 5;

	localparam int NODES_PER_CELL = 8;
	localparam int EDGES_PER_CELL = 12;
	localparam int SLOTS_PER_CELL = NODES_PER_CELL + EDGES_PER_CELL;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_CELL - 1);

	localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 2'd2;

	typedef enum logic [1:0] {
		DIR_NODE = 2'd0,
		DIR_X    = 2'd1,
		DIR_Y    = 2'd2,
		DIR_Z    = 2'd3
	} dir_t;

	typedef struct packed {
		dir_t dir;
		logic di;
		logic dj;
		logic dk;
	} slot_info_t;

	// Per-cell bases and strides handed from the front end to the back end.
	typedef struct packed {
		logic                  err;
		logic [CELL_IDX_W-1:0] cidx;
		logic [ID_W-1:0]       n0;
		logic [ID_W-1:0]       ex0;
		logic [ID_W-1:0]       ey0;
		logic [ID_W-1:0]       ez0;
		logic [ID_W-1:0]       nx;
		logic [ID_W-1:0]       nx1;
		logic [ID_W-1:0]       p11;
		logic [ID_W-1:0]       pxy1;
		logic [ID_W-1:0]       px1y;
	} desc_t;

	// Corners first, then the edges in local order.
	function automatic slot_info_t slot_info(input logic [SLOT_W-1:0] slot);
		slot_info_t r;
		case (slot)
			5'd0:    r = '{DIR_NODE, 1'b0, 1'b0, 1'b0};
			5'd1:    r = '{DIR_NODE, 1'b1, 1'b0, 1'b0};
			5'd2:    r = '{DIR_NODE, 1'b1, 1'b1, 1'b0};
			5'd3:    r = '{DIR_NODE, 1'b0, 1'b1, 1'b0};
			5'd4:    r = '{DIR_NODE, 1'b0, 1'b0, 1'b1};
			5'd5:    r = '{DIR_NODE, 1'b1, 1'b0, 1'b1};
			5'd6:    r = '{DIR_NODE, 1'b1, 1'b1, 1'b1};
			5'd7:    r = '{DIR_NODE, 1'b0, 1'b1, 1'b1};
			5'd8:    r = '{DIR_X,    1'b0, 1'b0, 1'b0};
			5'd9:    r = '{DIR_Y,    1'b1, 1'b0, 1'b0};
			5'd10:   r = '{DIR_X,    1'b0, 1'b1, 1'b0};
			5'd11:   r = '{DIR_Y,    1'b0, 1'b0, 1'b0};
			5'd12:   r = '{DIR_X,    1'b0, 1'b0, 1'b1};
			5'd13:   r = '{DIR_Y,    1'b1, 1'b0, 1'b1};
			5'd14:   r = '{DIR_X,    1'b0, 1'b1, 1'b1};
			5'd15:   r = '{DIR_Y,    1'b0, 1'b0, 1'b1};
			5'd16:   r = '{DIR_Z,    1'b0, 1'b0, 1'b0};
			5'd17:   r = '{DIR_Z,    1'b1, 1'b0, 1'b0};
			5'd18:   r = '{DIR_Z,    1'b1, 1'b1, 1'b0};
			5'd19:   r = '{DIR_Z,    1'b0, 1'b1, 1'b0};
			default: r = '{DIR_NODE, 1'b0, 1'b0, 1'b0};
		endcase
		return r;
	endfunction

endpackage

>>> design/hmc_front.sv
// Front end: size registers, input handshake, range check and a three-stage
// pipeline that builds the per-cell bases and strides. Depends on hmc_pkg.
module hmc_front import hmc_pkg::*; #(
	parameter int MAX_CELLS_PER_AXIS = MAX_CELLS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [COORD_W-1:0]   cell_i,
	input  logic [COORD_W-1:0]   cell_j,
	input  logic [COORD_W-1:0]   cell_k,
	output logic                 out_valid,
	input  logic                 out_ready,
	output desc_t                out_desc
);

	localparam int AW = $clog2(MAX_CELLS_PER_AXIS + 1);
	localparam int CW = (AW > CFG_W) ? AW : CFG_W;
	localparam int RW = (AW > COORD_W) ? AW : COORD_W;

	logic [CFG_W-1:0] cells_x_q, cells_y_q, cells_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= CFG_W'(1);
			cells_y_q <= CFG_W'(1);
			cells_z_q <= CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CELLS_X: cells_x_q <= cfg_data;
				REG_CELLS_Y: cells_y_q <= cfg_data;
				REG_CELLS_Z: cells_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [AW-1:0] eff_size(input logic [CFG_W-1:0] v);
		logic [CW-1:0] ext;
		ext = CW'(v);
		if (ext > CW'(MAX_CELLS_PER_AXIS))
			return AW'(MAX_CELLS_PER_AXIS);
		return AW'(ext);
	endfunction

	logic [AW-1:0] nx_c, ny_c, nz_c;
	logic          err_c;

	assign nx_c  = eff_size(cells_x_q);
	assign ny_c  = eff_size(cells_y_q);
	assign nz_c  = eff_size(cells_z_q);
	assign err_c = (RW'(cell_i) >= RW'(nx_c)) || (RW'(cell_j) >= RW'(ny_c))
		|| (RW'(cell_k) >= RW'(nz_c));

	logic rdy1, rdy2, rdy3;
	logic v_s1, v_s2, v_s3;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// Stage 1: captured coordinates and effective sizes.
	logic [COORD_W-1:0] i_s1, j_s1, k_s1;
	logic               err_s1;
	logic [AW-1:0]      nx_s1, ny_s1, nz_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			i_s1   <= cell_i;
			j_s1   <= cell_j;
			k_s1   <= cell_k;
			err_s1 <= err_c;
			nx_s1  <= nx_c;
			ny_s1  <= ny_c;
			nz_s1  <= nz_c;
		end
	end

	// Stage 2: plane strides and the j terms.
	logic [ID_W-1:0] nx1_c, ny1_c;
	assign nx1_c = ID_W'(nx_s1) + ID_W'(1);
	assign ny1_c = ID_W'(ny_s1) + ID_W'(1);

	logic [COORD_W-1:0] i_s2, k_s2;
	logic               err_s2;
	logic [AW-1:0]      nz_s2;
	logic [ID_W-1:0]    nx_s2, nx1_s2, jnx_s2, jnx1_s2;
	logic [ID_W-1:0]    pxy_s2, pxy1_s2, px1y_s2, p11_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			i_s2    <= i_s1;
			k_s2    <= k_s1;
			err_s2  <= err_s1;
			nz_s2   <= nz_s1;
			nx_s2   <= ID_W'(nx_s1);
			nx1_s2  <= nx1_c;
			jnx_s2  <= ID_W'(j_s1) * ID_W'(nx_s1);
			jnx1_s2 <= ID_W'(j_s1) * nx1_c;
			pxy_s2  <= ID_W'(nx_s1) * ID_W'(ny_s1);
			pxy1_s2 <= ID_W'(nx_s1) * ny1_c;
			px1y_s2 <= nx1_c * ID_W'(ny_s1);
			p11_s2  <= nx1_c * ny1_c;
		end
	end

	// Stage 3: k terms and the x- and y-edge counts.
	logic [ID_W-1:0] nz1_c;
	assign nz1_c = ID_W'(nz_s2) + ID_W'(1);

	logic [COORD_W-1:0] i_s3;
	logic               err_s3;
	logic [ID_W-1:0]    nx_s3, nx1_s3, p11_s3, pxy1_s3, px1y_s3, jnx_s3, jnx1_s3;
	logic [ID_W-1:0]    kpxy_s3, kpxy1_s3, kpx1y_s3, kp11_s3, nex_s3, ney_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			i_s3     <= i_s2;
			err_s3   <= err_s2;
			nx_s3    <= nx_s2;
			nx1_s3   <= nx1_s2;
			p11_s3   <= p11_s2;
			pxy1_s3  <= pxy1_s2;
			px1y_s3  <= px1y_s2;
			jnx_s3   <= jnx_s2;
			jnx1_s3  <= jnx1_s2;
			kpxy_s3  <= ID_W'(k_s2) * pxy_s2;
			kpxy1_s3 <= ID_W'(k_s2) * pxy1_s2;
			kpx1y_s3 <= ID_W'(k_s2) * px1y_s2;
			kp11_s3  <= ID_W'(k_s2) * p11_s2;
			nex_s3   <= pxy1_s2 * nz1_c;
			ney_s3   <= px1y_s2 * nz1_c;
		end
	end

	logic [ID_W-1:0] cidx_c, n0_c;

	assign cidx_c = ID_W'(i_s3) + jnx_s3 + kpxy_s3;
	assign n0_c   = ID_W'(i_s3) + jnx1_s3 + kp11_s3;

	always_comb begin
		out_desc.err  = err_s3;
		out_desc.cidx = cidx_c[CELL_IDX_W-1:0];
		out_desc.n0   = n0_c;
		out_desc.ex0  = ID_W'(i_s3) + jnx_s3 + kpxy1_s3;
		out_desc.ey0  = nex_s3 + ID_W'(i_s3) + jnx1_s3 + kpx1y_s3;
		out_desc.ez0  = nex_s3 + ney_s3 + n0_c;
		out_desc.nx   = nx_s3;
		out_desc.nx1  = nx1_s3;
		out_desc.p11  = p11_s3;
		out_desc.pxy1 = pxy1_s3;
		out_desc.px1y = px1y_s3;
	end

	assign out_valid = v_s3;

endmodule

>>> design/hmc_queue.sv
// Small register FIFO that decouples the front end from the back end.
// Depends on hmc_pkg for the default depth.
module hmc_queue import hmc_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1))
			return '0;
		return p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_data;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
		else $error("queue empty with pointers apart");

endmodule

>>> design/hmc_back.sv
// Back end: walks the twenty slots of one cell descriptor (a rejected cell gets one
// range-error beat) and drives the registered result stream. Depends on hmc_pkg.
module hmc_back import hmc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  desc_valid,
	output logic                  desc_ready,
	input  desc_t                 desc,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CELL_IDX_W-1:0] cell_index,
	output logic [SLOT_W-1:0]     slot,
	output logic                  is_edge,
	output logic [ID_W-1:0]       entity_id,
	output logic                  last_of_cell,
	output logic                  range_error
);

	logic              active_q;
	desc_t             d_q;
	logic [SLOT_W-1:0] slot_q;
	logic              ovalid_q;
	slot_info_t        info;
	logic              last_beat, load, take;
	logic [ID_W-1:0]   base, bj, bk, id_c;

	assign info      = slot_info(slot_q);
	assign last_beat = d_q.err || (slot_q == SLOT_LAST);
	assign load      = active_q && (!ovalid_q || out_ready);
	// The next descriptor is taken in the same cycle as the last beat of the current one.
	assign desc_ready = !active_q || (load && last_beat);
	assign take       = desc_valid && desc_ready;

	always_comb begin
		case (info.dir)
			DIR_NODE: begin
				base = d_q.n0;
				bj   = d_q.nx1;
				bk   = d_q.p11;
			end
			DIR_X: begin
				base = d_q.ex0;
				bj   = d_q.nx;
				bk   = d_q.pxy1;
			end
			DIR_Y: begin
				base = d_q.ey0;
				bj   = d_q.nx1;
				bk   = d_q.px1y;
			end
			DIR_Z: begin
				base = d_q.ez0;
				bj   = d_q.nx1;
				bk   = '0;
			end
			default: begin
				base = d_q.n0;
				bj   = d_q.nx1;
				bk   = d_q.p11;
			end
		endcase
		id_c = base + ID_W'(info.di) + (info.dj ? bj : '0) + (info.dk ? bk : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			slot_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (take) begin
				active_q <= 1'b1;
				slot_q   <= '0;
			end else if (load && last_beat) begin
				active_q <= 1'b0;
			end else if (load) begin
				slot_q <= slot_q + SLOT_W'(1);
			end
			if (load)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) d_q <= desc;
		if (load) begin
			if (d_q.err) begin
				cell_index   <= '0;
				slot         <= '0;
				is_edge      <= 1'b0;
				entity_id    <= '0;
				last_of_cell <= 1'b1;
				range_error  <= 1'b1;
			end else begin
				cell_index   <= d_q.cidx;
				slot         <= slot_q;
				is_edge      <= (info.dir != DIR_NODE);
				entity_id    <= id_c;
				last_of_cell <= (slot_q == SLOT_LAST);
				range_error  <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (slot_q <= SLOT_LAST))
		else $error("slot counter past last slot");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |-> (last_of_cell && entity_id == '0 && slot == '0))
		else $error("range error beat is not a lone closing beat");

	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_of_cell && !range_error) |-> (slot == SLOT_LAST))
		else $error("cell closed before its last edge");

endmodule

>>> design/hex_mesh_connectivity_gen_core.sv
// Top level of the hexahedral mesh connectivity generator.
// Depends on hmc_pkg, hmc_front, hmc_queue and hmc_back.

// Each accepted cell (i,j,k) yields twenty beats, eight corner node ids and then
// the edge ids, with tlast on the last edge id; a cell outside the configured grid
// yields one beat with the range error flag and tlast set. While a cell is in hand
// and m_axis_tready is high, the back end's output register issues one beat per
// cycle. The front end computes the per-cell bases in a three-stage pipeline and
// parks them in a two-entry queue, so it keeps taking cells while the back end is
// still emitting or stalled. There is no clearing pass after reset. Grid sizes
// above MAX_CELLS_PER_AXIS are clamped to it, and a size of zero rejects every cell.
module hex_mesh_connectivity_gen_core import hmc_pkg::*; #(
	parameter int MAX_CELLS_PER_AXIS = MAX_CELLS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,  // cell_i, cell_j, cell_k
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [55:0]          m_axis_tdata,  // cell_index, slot, entity_id, zero pad
	output logic [1:0]           m_axis_tuser,  // is_edge, range_error
	output logic                 m_axis_tlast
);

	localparam int DESC_W = $bits(desc_t);

	logic                  f_valid, f_ready, b_valid, b_ready;
	desc_t                 f_desc, b_desc;
	logic [DESC_W-1:0]     b_bits;
	logic [CELL_IDX_W-1:0] cell_index;
	logic [SLOT_W-1:0]     slot;
	logic                  is_edge, range_error;
	logic [ID_W-1:0]       entity_id;

	hmc_front #(
		.MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cell_i    (s_axis_tdata[7:0]),
		.cell_j    (s_axis_tdata[15:8]),
		.cell_k    (s_axis_tdata[23:16]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_desc  (f_desc)
	);

	hmc_queue #(
		.WIDTH(DESC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_desc),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_bits)
	);

	assign b_desc = desc_t'(b_bits);

	hmc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.desc_valid   (b_valid),
		.desc_ready   (b_ready),
		.desc         (b_desc),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.cell_index   (cell_index),
		.slot         (slot),
		.is_edge      (is_edge),
		.entity_id    (entity_id),
		.last_of_cell (m_axis_tlast),
		.range_error  (range_error)
	);

	assign m_axis_tdata = {1'b0, entity_id, slot, cell_index};
	assign m_axis_tuser = {range_error, is_edge};

endmodule
